/* sv/pin_identity_uart_beacon_unit_assert.svh */
// Assertion macros used by the beacon top level.
`ifndef PIN_IDENTITY_UART_BEACON_UNIT_ASSERT_SVH
`define PIN_IDENTITY_UART_BEACON_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PIUB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("beacon check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define PIUB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("beacon check failed: next-cycle implication");

`endif

/* sv/piub_pkg.sv */
// Package with the types, constants and helper functions of the UART beacon.
`timescale 1ns / 1ps

package piub_pkg;

    // Number of eight-pin ports that are driven; pins of higher ports read low.
    localparam int PORT_COUNT = 8;

    localparam int PIN_COUNT   = 64;
    localparam int TICK_W      = 13;
    localparam int BYTES_W     = 3;
    localparam int ID_W        = 32;
    localparam int BYTE_TICK_W = 8;
    localparam int PAUSE_W     = 12;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TICK_W-1:0]  TICK_MAX   = {TICK_W{1'b1}};
    localparam logic [BYTES_W-1:0] BURST_LEN  = 3'd5;
    localparam logic [TICK_W-1:0]  DATA_BITS  = 13'd8;

    localparam logic [ID_W-1:0]        BOARD_ID_RST   = 32'hDEADBEAF;
    localparam logic [BYTE_TICK_W-1:0] BYTE_TICKS_RST = 8'd24;
    localparam logic [PAUSE_W-1:0]     PAUSE_RST      = 12'd128;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOARD_ID   = 2'd0,
        CFG_BYTE_TICKS = 2'd1,
        CFG_PAUSE      = 2'd2
    } t_cfg_idx;

    // Line phase reported with every word.
    typedef enum logic [1:0] {
        PHASE_START = 2'd0,
        PHASE_DATA  = 2'd1,
        PHASE_IDLE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [ID_W-1:0]        board_id;
        logic [BYTE_TICK_W-1:0] byte_ticks;
        logic [PAUSE_W-1:0]     pause_ticks;
    } t_cfg;

    typedef struct packed {
        logic [TICK_W-1:0]  tick;
        logic [BYTES_W-1:0] bytes;
        logic [7:0]         shift;
    } t_state;

    typedef struct packed {
        logic [PIN_COUNT-1:0] pin_levels;
        t_phase               line_phase;
        logic                 ident;
    } t_result;

    // Pins that belong to driven ports.
    function automatic logic [PIN_COUNT-1:0] port_mask();
        logic [PIN_COUNT-1:0] m;
        m = '0;
        for (int p = 0; p < PORT_COUNT; p++) begin
            m[8*p +: 8] = 8'hFF;
        end
        return m;
    endfunction

    localparam logic [PIN_COUNT-1:0] PORT_MASK = port_mask();

    // Level of every pin for data bit b of its own identity byte.
    function automatic logic [PIN_COUNT-1:0] identity_levels(input logic [2:0] b);
        logic [PIN_COUNT-1:0] lv;
        logic [7:0]           id;
        lv = '0;
        for (int p = 0; p < PORT_COUNT; p++) begin
            for (int n = 0; n < 8; n++) begin
                id = {4'(p + 1), 1'b0, 3'(n)};
                lv[8*p+n] = id[b];
            end
        end
        return lv;
    endfunction

    // One settling pass: start the next byte, or arm a new burst after the pause.
    function automatic t_state settle_pass(input t_state s, input t_cfg c);
        t_state           r;
        logic [BYTES_W-1:0] nb;
        logic [1:0]       sel;
        r   = s;
        nb  = s.bytes - 3'd1;
        sel = 2'(nb - 3'd1);
        if ((s.tick > {5'd0, c.byte_ticks}) && (s.bytes != '0)) begin
            r.bytes = nb;
            r.shift = (nb != '0) ? 8'(c.board_id >> {sel, 3'b000}) : 8'h00;
            r.tick  = '0;
        end else if ((s.tick > {1'b0, c.pause_ticks}) && (s.bytes == '0)) begin
            r.bytes = BURST_LEN;
        end
        return r;
    endfunction

endpackage

/* sv/pin_identity_uart_beacon_unit.sv */
// Top level of the 64-pin bit-banged 8N1 UART beacon.
//
// Usage: each input word carries i_advance; a 1 advances one baud tick and a
// 0 does not advance the tick. Every accepted word yields exactly
// one output word: the 64 pin levels (bit 8*port+pin), the line phase and
// the pin-identity flag. A burst sends the four device-ID bytes, most
// significant first, then a per-pin identity byte, then a pause.
// An accepted word goes into the result register, or into the skid register
// while i_stall holds; one word per cycle is taken while o_stall is low.
// A two-entry output buffer (result register plus skid register) lets the
// block take a new word while a finished word is still held; o_stall rises
// only when both entries are full, and falls once the receiver takes a word.
// While i_stall is high the presented word holds steady.
// Reset (synchronous, active low) clears the buffer and the tick and byte
// state, so the block behaves as if an identity byte had just started, and
// loads the register defaults: device ID DEADBEAF, 24 ticks per byte slot,
// 128 pause ticks. Configuration is written through i_cfg_we, i_cfg_index
// and i_cfg_data while no word is in flight; unknown indexes are ignored.
`timescale 1ns / 1ps

`include "pin_identity_uart_beacon_unit_assert.svh"

module pin_identity_uart_beacon_unit
    import piub_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_advance,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIN_COUNT-1:0] o_pin_levels,
    output logic [1:0]           o_line_phase,
    output logic                 o_sending_pin_identity,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ID_W-1:0]      i_cfg_data
);

    t_cfg    r_cfg;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result core_result;
    logic    accept;
    logic    out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.board_id    <= BOARD_ID_RST;
            r_cfg.byte_ticks  <= BYTE_TICKS_RST;
            r_cfg.pause_ticks <= PAUSE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BOARD_ID:   r_cfg.board_id    <= i_cfg_data;
                CFG_BYTE_TICKS: r_cfg.byte_ticks  <= i_cfg_data[BYTE_TICK_W-1:0];
                CFG_PAUSE:      r_cfg.pause_ticks <= i_cfg_data[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: a word is taken whenever the skid entry is free.
    assign accept   = i_valid && !r_skid_valid;
    assign o_stall  = r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    piub_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_advance (i_advance),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    // Output buffer control: result register refills from skid first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : core_result;
        end else if (accept) begin
            r_skid <= core_result;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_pin_levels           = r_out.pin_levels;
    assign o_line_phase           = r_out.line_phase;
    assign o_sending_pin_identity = r_out.ident;

    // Checks on the buffer and the pin decode.
    `PIUB_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `PIUB_ASSERT_NEXT(a_accept_gives_word, i_clk, i_rst_n, accept, o_valid)
    `PIUB_ASSERT_NOW(a_start_bit_low, i_clk, i_rst_n,
        o_valid && (o_line_phase == PHASE_START), o_pin_levels == '0)
    `PIUB_ASSERT_NOW(a_id_data_uniform, i_clk, i_rst_n,
        o_valid && (o_line_phase == PHASE_DATA) && !o_sending_pin_identity,
        (o_pin_levels == '0) || (o_pin_levels == PORT_MASK))

endmodule

/* sv/piub_core.sv */
// Beacon sequencer: tick and byte state with the pin level decode of one word.
`timescale 1ns / 1ps

module piub_core
    import piub_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_advance,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_state r_state;
    t_state n_state;
    t_state s_tick;
    t_state s_pass1;
    logic [2:0] data_bit;

    // Saturating tick advance followed by two settling passes.
    always_comb begin
        s_tick = r_state;
        if (i_advance && (r_state.tick != TICK_MAX)) begin
            s_tick.tick = r_state.tick + 13'd1;
        end
        s_pass1 = settle_pass(s_tick, i_cfg);
        n_state = settle_pass(s_pass1, i_cfg);
    end

    // State moves only when a word is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    // Pin levels and flags decoded from the settled state.
    assign data_bit = 3'(n_state.tick - 13'd1);

    always_comb begin
        o_result.ident = (n_state.bytes == '0) &&
                         (n_state.tick <= {5'd0, i_cfg.byte_ticks});
        if (n_state.tick == '0) begin
            o_result.line_phase = PHASE_START;
            o_result.pin_levels = '0;
        end else if (n_state.tick <= DATA_BITS) begin
            o_result.line_phase = PHASE_DATA;
            if (n_state.bytes == '0) begin
                o_result.pin_levels = identity_levels(data_bit);
            end else begin
                o_result.pin_levels = n_state.shift[data_bit] ? PORT_MASK : '0;
            end
        end else begin
            o_result.line_phase = PHASE_IDLE;
            o_result.pin_levels = PORT_MASK;
        end
    end

endmodule

/* dv/tb_pin_identity_uart_beacon_unit.sv */
// Self-checking testbench for the 64-pin UART beacon with its own tick-level predictor.
`timescale 1ns / 1ps

module tb_pin_identity_uart_beacon_unit;
    import piub_pkg::*;

    // Register index that lies beyond the register list and must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RUN_LIMIT = 600000;

    typedef struct {
        logic advance;
        bit   drain_first;
    } t_beacon_in;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_advance = 1'b0;
    logic                 i_stall = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ID_W-1:0]      i_cfg_data = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [PIN_COUNT-1:0] o_pin_levels;
    logic [1:0]           o_line_phase;
    logic                 o_sending_pin_identity;

    // Predictor state and its copy of the registers.
    logic [TICK_W-1:0]      bc_tick = '0;
    logic [BYTES_W-1:0]     bc_bytes = '0;
    logic [7:0]             bc_shift = '0;
    logic [ID_W-1:0]        bc_board_id = BOARD_ID_RST;
    logic [BYTE_TICK_W-1:0] bc_byte_ticks = BYTE_TICKS_RST;
    logic [PAUSE_W-1:0]     bc_pause_ticks = PAUSE_RST;

    t_beacon_in pending_words[$];
    t_result    expected_words[$];

    int  words_predicted = 0;
    int  results_checked = 0;
    int  n_errors = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_run = 0;
    int  quiet_run = 0;
    int  results_outstanding;
    logic    word_taken;
    t_result got_word;
    t_result want_word;

    pin_identity_uart_beacon_unit DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_advance              (i_advance),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_pin_levels           (o_pin_levels),
        .o_line_phase           (o_line_phase),
        .o_sending_pin_identity (o_sending_pin_identity),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // All pins of the ports that are actually driven.
    function automatic logic [PIN_COUNT-1:0] driven_pins();
        logic [PIN_COUNT-1:0] m;
        m = '0;
        for (int p = 0; p < PORT_COUNT; p++) begin
            m[8*p +: 8] = 8'hFF;
        end
        return m;
    endfunction

    // Advance the beacon by one word and return the result word it reports.
    function automatic t_result advance_beacon(input logic advance);
        t_result    r;
        logic [2:0] bit_sel;
        logic [7:0] pin_id;
        if (advance && (bc_tick != TICK_MAX)) begin
            bc_tick = bc_tick + 13'd1;
        end
        // Two settling passes, so that a new burst loads its first byte at once.
        for (int pass = 0; pass < 2; pass++) begin
            if ((bc_tick > {5'd0, bc_byte_ticks}) && (bc_bytes != '0)) begin
                bc_bytes = bc_bytes - 3'd1;
                if (bc_bytes != '0) begin
                    bc_shift = 8'(bc_board_id >> {bc_bytes - 3'd1, 3'b000});
                end else begin
                    bc_shift = 8'h00;
                end
                bc_tick = '0;
            end else if ((bc_tick > {1'b0, bc_pause_ticks}) && (bc_bytes == '0)) begin
                bc_bytes = BURST_LEN;
            end
        end
        r.pin_levels = '0;
        if (bc_tick == '0) begin
            r.line_phase = PHASE_START;
        end else if (bc_tick <= DATA_BITS) begin
            r.line_phase = PHASE_DATA;
            bit_sel = 3'(bc_tick - 13'd1);
            if (bc_bytes == '0) begin
                // Identity byte: pin number low, port number plus one high.
                for (int p = 0; p < PORT_COUNT; p++) begin
                    for (int n = 0; n < 8; n++) begin
                        pin_id = {4'(p + 1), 1'b0, 3'(n)};
                        r.pin_levels[8*p+n] = pin_id[bit_sel];
                    end
                end
            end else if (bc_shift[bit_sel]) begin
                r.pin_levels = driven_pins();
            end
        end else begin
            r.line_phase = PHASE_IDLE;
            r.pin_levels = driven_pins();
        end
        r.ident = (bc_bytes == '0) && (bc_tick <= {5'd0, bc_byte_ticks});
        return r;
    endfunction

    // Driver: predicts each accepted word and presents queued words in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            word_taken = i_valid && !o_stall;
            if (word_taken) begin
                expected_words.push_back(advance_beacon(i_advance));
                words_predicted++;
            end
            results_outstanding = words_predicted - results_checked
                                  - ((o_valid && !i_stall) ? 1 : 0);
            if (i_valid && !word_taken) begin
                // Hold the stalled word as it is.
            end else if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if ((pending_words.size() != 0) &&
                         (!pending_words[0].drain_first || results_outstanding == 0)) begin
                i_valid   <= 1'b1;
                i_advance <= pending_words[0].advance;
                void'(pending_words.pop_front());
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result word and drives the stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked <= results_checked + 1;
            got_word.pin_levels = o_pin_levels;
            got_word.line_phase = t_phase'(o_line_phase);
            got_word.ident      = o_sending_pin_identity;
            if (expected_words.size() == 0) begin
                $display("%0t: result word with none expected, actual %h %0d %0d",
                         $time, o_pin_levels, o_line_phase, o_sending_pin_identity);
                n_errors++;
            end else begin
                want_word = expected_words.pop_front();
                if (got_word.pin_levels !== want_word.pin_levels) begin
                    $display("%0t: pin_levels expected %h actual %h",
                             $time, want_word.pin_levels, got_word.pin_levels);
                    n_errors++;
                end
                if (got_word.line_phase !== want_word.line_phase) begin
                    $display("%0t: line_phase expected %0d actual %0d",
                             $time, want_word.line_phase, o_line_phase);
                    n_errors++;
                end
                if (got_word.ident !== want_word.ident) begin
                    $display("%0t: sending_pin_identity expected %0d actual %0d",
                             $time, want_word.ident, got_word.ident);
                    n_errors++;
                end
            end
        end
        // Short stall runs and quiet stretches of random length follow in random order.
        if (stall_run != 0) begin
            i_stall <= 1'b1;
            stall_run--;
        end else if (quiet_run != 0) begin
            i_stall <= 1'b0;
            quiet_run--;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(1) == 1) begin
                stall_run = $urandom_range(1, 6);
            end else begin
                quiet_run = $urandom_range(1, 48);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_BOARD_ID:   bc_board_id    = data;
            CFG_BYTE_TICKS: bc_byte_ticks  = data[BYTE_TICK_W-1:0];
            CFG_PAUSE:      bc_pause_ticks = data[PAUSE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_words(input int count, input int adv_pct);
        t_beacon_in w;
        @(negedge i_clk);
        for (int k = 0; k < count; k++) begin
            w.advance     = ($urandom_range(99) < adv_pct);
            w.drain_first = ($urandom_range(999) < 4);
            pending_words.push_back(w);
        end
    endtask

    task automatic queue_word(input logic advance, input bit drain_first);
        t_beacon_in w;
        w.advance     = advance;
        w.drain_first = drain_first;
        pending_words.push_back(w);
    endtask

    // Wait until every queued word has gone in and every result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || expected_words.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input logic [ID_W-1:0] dev_id, input int byte_ticks,
                             input int pause_ticks, input int count, input int adv_pct);
        write_reg(CFG_BOARD_ID, dev_id);
        write_reg(CFG_BYTE_TICKS, ID_W'(byte_ticks));
        write_reg(CFG_PAUSE, ID_W'(pause_ticks));
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_UNUSED, $urandom);
        end
        end_writes();
        queue_words(count, adv_pct);
        wait_idle();
    endtask

    // Timeout guard.
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Sequence of phases.
    initial begin
        int random_words;
        int len;
        int bt;
        int pause;
        random_words = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset: the identity byte is in flight at the start bit.
        // A write to an unused index must leave everything unchanged.
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        end_writes();
        @(negedge i_clk);
        queue_word(1'b0, 1'b0);
        repeat (21) queue_word(1'b1, 1'b0);
        queue_word(1'b0, 1'b1);
        queue_word(1'b1, 1'b0);
        queue_word(1'b1, 1'b0);
        wait_idle();

        // Shortest byte slot and pause with an all-zero identifier.
        run_phase(32'h0000_0000, 10, 10, 120, 90);

        // A long pause cut short by a register write, seen on words without a tick.
        run_phase(32'hFFFF_FFFF, 10, 4095, 200, 100);
        write_reg(CFG_PAUSE, ID_W'(10));
        end_writes();
        @(negedge i_clk);
        repeat (3) queue_word(1'b0, 1'b0);
        wait_idle();

        // Pause shorter than the byte slot, at the widest byte slot.
        run_phase($urandom, 255, 10, 300, 100);

        // Widest byte slot with the longest pause.
        run_phase($urandom, 255, 4095, 300, 100);

        // Random phases, mostly with short slots so that bursts complete.
        while (random_words < 650) begin
            len = $urandom_range(80, 240);
            case ($urandom_range(7))
                0: begin
                    bt    = $urandom_range(40, 255);
                    pause = $urandom_range(10, 4095);
                end
                1: begin
                    bt    = $urandom_range(20, 40);
                    pause = $urandom_range(10, bt - 1);
                end
                default: begin
                    bt    = $urandom_range(10, 24);
                    pause = $urandom_range(10, 60);
                end
            endcase
            run_phase($urandom, bt, pause, len, $urandom_range(60, 100));
            random_words += len;
        end

        wait_idle();
        repeat (4) @(negedge i_clk);
        if (expected_words.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, expected_words.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
